FILE: rtl/pfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; imported by every other file of the block.
package pfa_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC      = 2'd0;
  localparam logic [1:0] CMD_MARK_USED  = 2'd1;
  localparam logic [1:0] CMD_MARK_FREE  = 2'd2;
  localparam logic [1:0] CMD_MARK_RANGE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [31:0] PHYS_BASE    = 32'h0010_0000;
  localparam int          PAGE_SHIFT   = 12;
  localparam logic [31:0] WORD_FULL    = 32'hFFFF_FFFF;
  localparam logic [4:0]  WORD_MSB     = 5'd31;
  localparam logic [15:0] MP_RESET     = 16'h8000;

  // Controller -> datapath
  typedef struct packed {
    logic       ld_in;        // capture the input item
    logic       w_zero;       // word pointer to 0
    logic       w_start;      // word pointer to the start page's word
    logic       w_inc;        // word pointer advance
    logic       mem_rd;       // read bitmap word at pointer
    logic       mem_clr;      // write zero at pointer
    logic       mem_wr;       // write modified word at pointer
    logic       res_load;     // latch result
    logic [1:0] res_status;
    logic       res_addr_en;  // result carries the found page address
    logic       out_load;     // move result into output register
  } pfa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       limit_zero;
    logic       a_ok;
    logic       range_ok;
    logic       found;
    logic       last_word;
    logic       clr_done;
  } pfa_sts_t;

endpackage

FILE: rtl/pfa_dpath.sv
// Datapath of the page frame allocator: bitmap memory, word pointer,
// address checks, free-bit search and result registers. Uses pfa_pkg.
module pfa_dpath #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [1:0]        command_i,
  input  logic [31:0]       page_address_i,
  input  logic [31:0]       range_end_address_i,
  input  pfa_pkg::pfa_cmd_t cmd_i,
  output pfa_pkg::pfa_sts_t sts_o,
  output logic [31:0]       allocated_address_o,
  output logic [1:0]        status_o
);
  import pfa_pkg::*;

  localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [31:0]   PAGE_CAP  = 32'(BITMAP_WORDS) << 5;
  localparam logic [WW-1:0] LAST_WORD = WW'(BITMAP_WORDS - 1);

  logic [31:0]   mem_q [BITMAP_WORDS];
  logic [31:0]   rdata_q;
  logic [WW-1:0] w_q, w_d;
  logic [15:0]   mp_q;
  logic [1:0]    cmd_q;
  logic [31:0]   addr_q, end_q;
  logic [1:0]    res_status_q, out_status_q;
  logic [31:0]   res_addr_q, out_addr_q;

  logic [15:0]   limit, lim_m1;
  logic [19:0]   pa20, pe20;
  logic [15:0]   pa16, pe16;
  logic          a_ok, e_ok;
  logic [WW-1:0] start_w, end_w, alloc_last_w, last_w_sel;
  logic [31:0]   valid_mask, avail, low_bit;
  logic [4:0]    low_idx;
  logic [15:0]   found_page;
  logic [31:0]   found_addr;
  logic [4:0]    rng_lo, rng_hi;
  logic [31:0]   rng_mask, bit_mask, wdata;

  // managed count clipped to the bitmap size
  assign limit  = ({16'h0000, mp_q} < PAGE_CAP) ? mp_q : PAGE_CAP[15:0];
  assign lim_m1 = limit - 16'd1;

  assign pa20 = addr_q[31:PAGE_SHIFT] - PHYS_BASE[31:PAGE_SHIFT];
  assign pe20 = end_q[31:PAGE_SHIFT] - PHYS_BASE[31:PAGE_SHIFT];
  assign pa16 = pa20[15:0];
  assign pe16 = pe20[15:0];
  assign a_ok = (addr_q[PAGE_SHIFT-1:0] == '0) && (addr_q >= PHYS_BASE) &&
                (pa20 < {4'h0, limit});
  assign e_ok = (end_q[PAGE_SHIFT-1:0] == '0) && (end_q >= PHYS_BASE) &&
                (pe20 < {4'h0, limit});

  assign start_w      = WW'(pa16 >> 5);
  assign end_w        = WW'(pe16 >> 5);
  assign alloc_last_w = WW'(lim_m1 >> 5);
  assign last_w_sel   = (cmd_q == CMD_ALLOC) ? alloc_last_w : end_w;

  // free-bit search: bits past the managed count read as used
  assign valid_mask = (w_q == alloc_last_w) ? (WORD_FULL >> (WORD_MSB - lim_m1[4:0]))
                                            : WORD_FULL;
  assign avail   = ~rdata_q & valid_mask;
  assign low_bit = avail & (~avail + 32'd1);

  always_comb begin
    low_idx = '0;
    for (int b = 0; b < 5; b++) begin
      for (int k = 0; k < 32; k++) begin
        if (((k >> b) & 1) == 1) low_idx[b] = low_idx[b] | low_bit[k];
      end
    end
  end

  assign found_page = 16'({w_q, low_idx});
  assign found_addr = 32'({found_page, 12'h000}) + PHYS_BASE;

  assign rng_lo   = (w_q == start_w) ? pa16[4:0] : 5'd0;
  assign rng_hi   = (w_q == end_w) ? pe16[4:0] : WORD_MSB;
  assign rng_mask = (WORD_FULL << rng_lo) & (WORD_FULL >> (WORD_MSB - rng_hi));
  assign bit_mask = 32'd1 << pa16[4:0];

  always_comb begin
    case (cmd_q)
      CMD_ALLOC:     wdata = rdata_q | low_bit;
      CMD_MARK_USED: wdata = rdata_q | bit_mask;
      CMD_MARK_FREE: wdata = rdata_q & ~bit_mask;
      default:       wdata = rdata_q | rng_mask;
    endcase
  end

  always_comb begin
    if (cmd_i.w_zero) begin
      w_d = '0;
    end else if (cmd_i.w_start) begin
      w_d = start_w;
    end else if (cmd_i.w_inc) begin
      w_d = w_q + 1'b1;
    end else begin
      w_d = w_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= '0;
      mp_q <= MP_RESET;
    end else begin
      w_q <= w_d;
      if (cfg_we_i) mp_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_clr) begin
      mem_q[w_q] <= '0;
    end else if (cmd_i.mem_wr) begin
      mem_q[w_q] <= wdata;
    end
    if (cmd_i.mem_rd) rdata_q <= mem_q[w_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      cmd_q  <= command_i;
      addr_q <= page_address_i;
      end_q  <= range_end_address_i;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= cmd_i.res_addr_en ? found_addr : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.limit_zero = (limit == '0);
  assign sts_o.a_ok       = a_ok;
  assign sts_o.range_ok   = a_ok && e_ok && (pa16 <= pe16);
  assign sts_o.found      = (avail != '0);
  assign sts_o.last_word  = (w_q == last_w_sel);
  assign sts_o.clr_done   = (w_q == LAST_WORD);

  assign allocated_address_o = out_addr_q;
  assign status_o            = out_status_q;

endmodule

FILE: rtl/pfa_ctrl.sv
// Controller of the page frame allocator: clearing sweep, command
// sequencing and handshakes. Uses pfa_pkg; drives pfa_dpath.
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_MODIFY,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_clr = 1'b1;
        cmd_o.w_inc   = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts_i.cmd) inside
          CMD_ALLOC: begin
            if (sts_i.limit_zero) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = S_FINISH;
            end else begin
              cmd_o.w_zero = 1'b1;
              state_d      = S_READ;
            end
          end
          CMD_MARK_USED, CMD_MARK_FREE: begin
            if (sts_i.a_ok) begin
              cmd_o.w_start = 1'b1;
              state_d       = S_READ;
            end else begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INVALID;
              state_d          = S_FINISH;
            end
          end
          default: begin
            if (sts_i.range_ok) begin
              cmd_o.w_start = 1'b1;
              state_d       = S_READ;
            end else begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_INVALID;
              state_d          = S_FINISH;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_MODIFY;
      end
      S_MODIFY: begin
        unique case (sts_i.cmd) inside
          CMD_ALLOC: begin
            if (sts_i.found) begin
              cmd_o.mem_wr      = 1'b1;
              cmd_o.res_load    = 1'b1;
              cmd_o.res_status  = ST_OK;
              cmd_o.res_addr_en = 1'b1;
              state_d           = S_FINISH;
            end else if (sts_i.last_word) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = S_FINISH;
            end else begin
              cmd_o.w_inc = 1'b1;
              state_d     = S_READ;
            end
          end
          CMD_MARK_USED, CMD_MARK_FREE: begin
            cmd_o.mem_wr     = 1'b1;
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_OK;
            state_d          = S_FINISH;
          end
          default: begin
            cmd_o.mem_wr = 1'b1;
            if (sts_i.last_word) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_OK;
              state_d          = S_FINISH;
            end else begin
              cmd_o.w_inc = 1'b1;
              state_d     = S_READ;
            end
          end
        endcase
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator.
// Instantiates pfa_ctrl and pfa_dpath; uses pfa_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   allocate, mark page used, mark page free or mark range used. Output
//   channel (out_valid_o/out_ready_i) returns one result per command:
//   allocated_address_o and status_o. cfg port writes managed_pages; it is
//   always ready and should only be written while the block is idle.
//   One bitmap word of 32 pages is handled per read-modify-write through
//   the single bitmap RAM port. After its transfer an item passes the
//   check state, then a read and a modify state for each of the W words
//   visited: one for a single-page mark, the words up to the first free
//   page for allocate, the spanned words for a range; the finish state
//   then loads the output. Invalid commands go from the check state
//   straight to finish. The next item is taken in the cycle after the
//   load; a new item is accepted only once the last one has been loaded.
//   After reset the bitmap is zeroed one word per cycle, all words, with
//   in_ready_o low. A stalled output holds its result; the next item is
//   accepted and worked on, and waits for the output register only when done.
module bitmap_page_frame_allocator #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] page_address_i,
  input  logic [31:0] range_end_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] allocated_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_managed_pages_i
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfa_dpath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_data_i          (cfg_managed_pages_i),
    .command_i           (command_i),
    .page_address_i      (page_address_i),
    .range_end_address_i (range_end_address_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .allocated_address_o (allocated_address_o),
    .status_o            (status_o)
  );

endmodule

FILE: rtl/pfa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level.
// Uses pfa_pkg for status codes and the base address.
module pfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] allocated_address_o,
  input logic [1:0]  status_o
);
  import pfa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(allocated_address_o) && $stable(status_o))
    else $error("output changed while stalled");

  // one item at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an input transfer");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (allocated_address_o == '0))
    else $error("nonzero address with failing status");

  a_addr_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) && (allocated_address_o != '0) |->
      (allocated_address_o[PAGE_SHIFT-1:0] == '0) && (allocated_address_o >= PHYS_BASE))
    else $error("allocated address misaligned or below base");

endmodule

bind bitmap_page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .allocated_address_o (allocated_address_o),
  .status_o            (status_o)
);
